/* design/bba_pkg.sv */
// Shared types, constants and helpers for the block bitmap allocator.
// Used by bba_free_find, bba_engine and block_bitmap_allocator_with_links.
// No dependencies.
package bba_pkg;

    // Pool geometry
    localparam int POOL_BLOCKS = 256;
    localparam int BLK_W       = $clog2(POOL_BLOCKS);
    localparam int WORD_W      = (POOL_BLOCKS < 32) ? (2 ** $clog2(POOL_BLOCKS)) : 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int ROWS        = (POOL_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int STEP_W      = $clog2(POOL_BLOCKS + 1);

    // Field widths
    localparam int FUNC_W = 3;
    localparam int IDX_W  = 8;
    localparam int RES_W  = 9;

    // Result code for "no block"
    localparam logic [RES_W-1:0] RES_NONE = {RES_W{1'b1}};

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_EXT   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TAIL  = 3'd4;

    // Link entry: none flag plus block number
    typedef struct packed {
        logic             none;
        logic [BLK_W-1:0] idx;
    } t_link;

    localparam t_link LINK_NONE = '{none: 1'b1, idx: '0};

    // Free-bit search result
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
    } t_hit;

    // Finished result handed to the output stage
    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] value;
    } t_res;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EXT,
        S_FREE,
        S_LINK,
        S_WALK,
        S_DONE
    } t_state;

    // Bits of a map row that belong to the pool
    function automatic logic [WORD_W-1:0] row_mask(input logic [ROW_W-1:0] row);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = ((int'(row) * WORD_W + b) < POOL_BLOCKS);
        end
        return m;
    endfunction

    function automatic logic [ROW_W-1:0] row_of(input logic [BLK_W-1:0] blk);
        return ROW_W'(blk >> BIT_W);
    endfunction

    function automatic logic [BIT_W-1:0] bit_of(input logic [BLK_W-1:0] blk);
        return BIT_W'(blk);
    endfunction

    function automatic logic [BLK_W-1:0] blk_of(input logic [ROW_W-1:0] row,
                                                 input logic [BIT_W-1:0] bit_idx);
        return BLK_W'({row, bit_idx});
    endfunction

    function automatic logic [RES_W-1:0] res_of_blk(input logic [BLK_W-1:0] blk);
        return RES_W'(blk);
    endfunction

    function automatic logic [RES_W-1:0] res_of_link(input t_link lnk);
        return lnk.none ? RES_NONE : RES_W'(lnk.idx);
    endfunction

endpackage

/* design/bba_free_find.sv */
// Lowest-free-block search over one row of the used map.
// Depends on bba_pkg for geometry and the t_hit type.
module bba_free_find (
    input  logic [bba_pkg::WORD_W-1:0] i_word,
    input  logic [bba_pkg::ROW_W-1:0]  i_row,
    output bba_pkg::t_hit              o_hit
);
    import bba_pkg::*;

    logic [WORD_W-1:0] avail;

    // Mask off bits past the pool and the reserved block
    always_comb begin
        avail = ~i_word & row_mask(i_row);
        if (i_row == '0) begin
            avail[0] = 1'b0;
        end
    end

    // Priority encode, lowest index wins
    always_comb begin
        o_hit.found   = |avail;
        o_hit.bit_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (avail[b]) begin
                o_hit.bit_idx = BIT_W'(b);
            end
        end
    end

endmodule

/* design/bba_engine.sv */
// Sequencer with the used-map and link memories: clear, scan, free, link read, tail walk.
// Depends on bba_pkg and bba_free_find.
module bba_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [bba_pkg::FUNC_W-1:0] i_func,
    input  logic [bba_pkg::IDX_W-1:0]  i_block_index,
    input  logic                       i_slot_free,
    output logic                       o_busy,
    output bba_pkg::t_res              o_done
);
    import bba_pkg::*;

    localparam logic [BLK_W-1:0]  LAST_BLK = BLK_W'(POOL_BLOCKS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [STEP_W-1:0] MAX_STEP = STEP_W'(POOL_BLOCKS);

    // Memories and their registered read data
    logic [WORD_W-1:0] r_used_mem [ROWS];
    t_link             r_link_mem [POOL_BLOCKS];
    logic [WORD_W-1:0] r_used_q;
    t_link             r_link_q;

    // Memory port controls
    logic [ROW_W-1:0]  used_rd_row;
    logic              used_we;
    logic [ROW_W-1:0]  used_wr_row;
    logic [WORD_W-1:0] used_wr_data;
    logic [BLK_W-1:0]  link_rd_addr;
    logic              link_we;
    logic [BLK_W-1:0]  link_wr_addr;
    t_link             link_wr_data;

    // Sequencer state
    t_state            r_state, n_state;
    logic [BLK_W-1:0]  r_clr, n_clr;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [BLK_W-1:0]  r_idx, n_idx;
    logic              r_inside, n_inside;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [BLK_W-1:0]  r_cur, n_cur;
    logic [BLK_W-1:0]  r_last, n_last;
    logic [STEP_W-1:0] r_steps, n_steps;
    t_link             r_alloc, n_alloc;
    logic [RES_W-1:0]  r_res, n_res;

    // Decoded input and walk helpers
    logic [BLK_W-1:0]  in_idx;
    logic              in_inside;
    logic              walk_used;
    logic [STEP_W-1:0] walk_steps;
    logic              walk_stop;
    t_hit              hit;
    logic [BLK_W-1:0]  hit_blk;

    assign in_idx     = BLK_W'(i_block_index);
    assign in_inside  = (int'(i_block_index) < POOL_BLOCKS);
    assign walk_used  = r_used_q[bit_of(r_cur)];
    assign walk_steps = r_steps + STEP_W'(1);
    assign walk_stop  = r_link_q.none || (r_link_q.idx == '0) || (walk_steps == MAX_STEP);
    assign hit_blk    = blk_of(r_row, hit.bit_idx);
    assign o_busy     = (r_state != S_IDLE);

    bba_free_find u_find (
        .i_word (r_used_q),
        .i_row  (r_row),
        .o_hit  (hit)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_BLK) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_func) inside
                        FN_ALLOC, FN_EXT: n_state = S_SCAN;
                        FN_FREE:          n_state = in_inside ? S_FREE : S_DONE;
                        FN_READ:          n_state = in_inside ? S_LINK : S_DONE;
                        FN_TAIL: begin
                            n_state = (in_inside && (in_idx != '0)) ? S_WALK : S_DONE;
                        end
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit.found || (r_row == LAST_ROW)) begin
                    n_state = (r_func == FN_EXT) ? S_EXT : S_DONE;
                end
            end
            S_EXT:  n_state = S_DONE;
            S_FREE: n_state = S_DONE;
            S_LINK: n_state = S_DONE;
            S_WALK: begin
                if (!walk_used || walk_stop) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory ports and result hand-off
    always_comb begin
        n_clr        = r_clr;
        n_func       = r_func;
        n_idx        = r_idx;
        n_inside     = r_inside;
        n_row        = r_row;
        n_cur        = r_cur;
        n_last       = r_last;
        n_steps      = r_steps;
        n_alloc      = r_alloc;
        n_res        = r_res;
        used_rd_row  = '0;
        used_we      = 1'b0;
        used_wr_row  = '0;
        used_wr_data = '0;
        link_rd_addr = '0;
        link_we      = 1'b0;
        link_wr_addr = '0;
        link_wr_data = LINK_NONE;
        o_done.valid = 1'b0;
        o_done.value = r_res;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep links to none, rows to free with block 0 reserved
                link_we      = 1'b1;
                link_wr_addr = r_clr;
                link_wr_data = LINK_NONE;
                if (int'(r_clr) < ROWS) begin
                    used_we      = 1'b1;
                    used_wr_row  = ROW_W'(r_clr);
                    used_wr_data = (r_clr == '0) ? WORD_W'(1) : '0;
                end
                n_clr = r_clr + BLK_W'(1);
            end
            S_IDLE: begin
                // Capture the transfer and issue the first reads
                n_func   = i_func;
                n_idx    = in_idx;
                n_inside = in_inside;
                n_row    = '0;
                n_res    = RES_NONE;
                n_cur    = in_idx;
                n_last   = in_idx;
                n_steps  = '0;
                if (i_func == FN_TAIL) begin
                    n_res = RES_W'(i_block_index);
                end
                if (i_func == FN_FREE || i_func == FN_TAIL) begin
                    used_rd_row = row_of(in_idx);
                end
                link_rd_addr = in_idx;
            end
            S_SCAN: begin
                if (hit.found) begin
                    // Claim the block and clear its link
                    used_we      = 1'b1;
                    used_wr_row  = r_row;
                    used_wr_data = r_used_q | (WORD_W'(1) << hit.bit_idx);
                    link_we      = 1'b1;
                    link_wr_addr = hit_blk;
                    link_wr_data = LINK_NONE;
                    n_res        = res_of_blk(hit_blk);
                    n_alloc      = '{none: 1'b0, idx: hit_blk};
                end else if (r_row == LAST_ROW) begin
                    n_res   = RES_NONE;
                    n_alloc = LINK_NONE;
                end else begin
                    n_row       = r_row + ROW_W'(1);
                    used_rd_row = r_row + ROW_W'(1);
                end
            end
            S_EXT: begin
                // Chain the new block (or none) behind the given one
                if (r_inside) begin
                    link_we      = 1'b1;
                    link_wr_addr = r_idx;
                    link_wr_data = r_alloc;
                end
            end
            S_FREE: begin
                used_we      = 1'b1;
                used_wr_row  = row_of(r_idx);
                used_wr_data = r_used_q & ~(WORD_W'(1) << bit_of(r_idx));
                n_res        = RES_NONE;
            end
            S_LINK: begin
                n_res = res_of_link(r_link_q);
            end
            S_WALK: begin
                // Advance one link per cycle while the block is in use
                if (walk_used) begin
                    n_last  = r_cur;
                    n_steps = walk_steps;
                    if (walk_stop) begin
                        n_res = res_of_blk(r_cur);
                    end else begin
                        n_cur        = r_link_q.idx;
                        used_rd_row  = row_of(r_link_q.idx);
                        link_rd_addr = r_link_q.idx;
                    end
                end else begin
                    n_res = res_of_blk(r_last);
                end
            end
            S_DONE: begin
                o_done.valid = i_slot_free;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_idx    <= n_idx;
        r_inside <= n_inside;
        r_row    <= n_row;
        r_cur    <= n_cur;
        r_last   <= n_last;
        r_steps  <= n_steps;
        r_alloc  <= n_alloc;
        r_res    <= n_res;
    end

    // Used-map memory, one row read and one row written per cycle
    always_ff @(posedge i_clk) begin
        if (used_we) begin
            r_used_mem[used_wr_row] <= used_wr_data;
        end
        r_used_q <= r_used_mem[used_rd_row];
    end

    // Link memory, one read and one write per cycle
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_wr_addr] <= link_wr_data;
        end
        r_link_q <= r_link_mem[link_rd_addr];
    end

`ifndef NO_ASSERTIONS
    // Allocation never hands out the reserved block
    a_no_block0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && hit.found) |-> (hit_blk != '0))
        else $error("allocator picked reserved block");

    // A map write is never followed by a read of stale map data
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (used_we && r_state != S_CLEAR) |->
            (n_state != S_SCAN && n_state != S_WALK && n_state != S_FREE))
        else $error("map write overlaps a dependent read");

    // The extension link write follows the scan that produced it
    a_ext_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXT) |-> ($past(r_state) == S_SCAN))
        else $error("extension link write without scan");

    // The tail walk stays within its step cap
    a_walk_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps < MAX_STEP))
        else $error("tail walk exceeded step cap");
`endif

endmodule

/* design/block_bitmap_allocator_with_links.sv */
// Top level of the block bitmap allocator with chain links: output register and hookup.
// Depends on bba_pkg and bba_engine.
//
// Allocates blocks from a pool of POOL_BLOCKS (256), keeps a used bit and a next-block
// link per block, and serves allocate, free, allocate-extension, read-link and
// find-tail, one operation at a time with one result each. After reset the block
// runs a clearing pass through the link memory and the map rows before it takes the
// first transfer. Allocate scans the 32-bit map rows in order (1 to 8 of them), the
// map memory yielding one row per cycle; allocate-extension adds a link write after
// the scan; find-tail examines blocks along the chain (the last one may be a free
// block that ends the walk), one link-memory read per step, capped at POOL_BLOCKS
// steps. A finished result sits in an output register, so the next transfer is
// accepted while it waits to be taken.
module block_bitmap_allocator_with_links (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bba_pkg::FUNC_W-1:0]        i_func,
    input  logic [bba_pkg::IDX_W-1:0]         i_block_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [bba_pkg::RES_W-1:0]  o_result_block
);
    import bba_pkg::*;

    logic             r_out_valid, n_out_valid;
    logic [RES_W-1:0] r_out_result, n_out_result;
    logic             slot_free;
    logic             busy;
    t_res             done;

    // Output slot is free when empty or being drained this cycle
    assign slot_free = !r_out_valid || !i_out_stall;

    bba_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_func        (i_func),
        .i_block_index (i_block_index),
        .i_slot_free   (slot_free),
        .o_busy        (busy),
        .o_done        (done)
    );

    // Load a finished result, drop it once transferred
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_result = r_out_result;
        if (done.valid) begin
            n_out_valid  = 1'b1;
            n_out_result = done.value;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_result <= n_out_result;
    end

    assign o_in_stall     = busy;
    assign o_out_valid    = r_out_valid;
    assign o_result_block = signed'(r_out_result);

endmodule
